// File: hdl/pso_particle_update_macros.svh
// Assertion macros for the particle update block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PSO_PARTICLE_UPDATE_MACROS_SVH
`define PSO_PARTICLE_UPDATE_MACROS_SVH

`ifndef SYNTH
`define PSO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define PSO_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define PSO_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define PSO_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hdl/pso_pkg.sv
// Shared types and constants of the particle update block.
// No dependencies; imported by pso_mac and pso_particle_update.
package pso_pkg;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_COST = 2'd1;
   localparam logic [1:0] REQ_MOVE = 2'd2;

   localparam logic [1:0] CSR_OWN_GAIN    = 2'd0;
   localparam logic [1:0] CSR_GLOBAL_GAIN = 2'd1;
   localparam logic [1:0] CSR_MOMENTUM    = 2'd2;
   localparam logic [1:0] CSR_VMAX_FRAC   = 2'd3;

   localparam logic [15:0] OWN_GAIN_RST    = 16'd8192;
   localparam logic [15:0] GLOBAL_GAIN_RST = 16'd8192;
   localparam logic [15:0] MOMENTUM_RST    = 16'd2867;
   localparam logic [15:0] VMAX_FRAC_RST   = 16'd6554;

   localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         dim_index;
      logic signed [31:0] load_position;
      logic signed [31:0] load_velocity;
      logic signed [31:0] bound_low;
      logic signed [31:0] bound_high;
      logic signed [31:0] cost_value;
      logic [15:0]        rand_own;
      logic [15:0]        rand_global;
      logic signed [31:0] swarm_best_coord;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] new_position;
      logic signed [31:0] new_velocity;
      logic               improved;
      logic signed [31:0] personal_best_cost;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] own_best_gain;
      logic [15:0] global_best_gain;
      logic [15:0] momentum_gain;
      logic [15:0] vmax_fraction;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_K1,
      MUL_K2,
      MUL_MOM,
      MUL_OWN,
      MUL_SWARM,
      MUL_SPAN
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP,
      ST_SWEEP_TAIL,
      ST_READ,
      ST_K1,
      ST_K2,
      ST_MOM,
      ST_OWN,
      ST_SWARM,
      ST_SPAN,
      ST_CLAMP,
      ST_POS,
      ST_DONE
   } state_type;

endpackage

// File: hdl/pso_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pso_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/pso_mac.sv
// Shared 17x33 signed multiplier with product register, gain registers and
// accumulator for the velocity sum. Depends on pso_pkg.
module pso_mac (
   input  logic                clock,
   input  pso_pkg::mul_op_type op,
   input  pso_pkg::cfg_type    cfg,
   input  logic [15:0]         rand_own,
   input  logic [15:0]         rand_global,
   input  logic signed [31:0]  velocity,
   input  logic signed [32:0]  own_diff,
   input  logic signed [32:0]  swarm_diff,
   input  logic signed [32:0]  span,
   output logic signed [49:0]  product,
   output logic signed [39:0]  acc
);
   import pso_pkg::*;

   logic signed [16:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [49:0] product_ff, product_in;
   logic [15:0]        k1_ff, k2_ff;
   logic signed [39:0] acc_ff;
   logic signed [39:0] term;

   always_comb begin
      case (op)
         MUL_K1: begin
            mul_a = {1'b0, cfg.own_best_gain};
            mul_b = {17'd0, rand_own};
         end
         MUL_K2: begin
            mul_a = {1'b0, cfg.global_best_gain};
            mul_b = {17'd0, rand_global};
         end
         MUL_MOM: begin
            mul_a = {1'b0, cfg.momentum_gain};
            mul_b = {velocity[31], velocity};
         end
         MUL_OWN: begin
            mul_a = {1'b0, k1_ff};
            mul_b = own_diff;
         end
         MUL_SWARM: begin
            mul_a = {1'b0, k2_ff};
            mul_b = swarm_diff;
         end
         MUL_SPAN: begin
            mul_a = {1'b0, cfg.vmax_fraction};
            mul_b = span;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product_in = mul_a * mul_b;
   assign term       = {{2{product_ff[49]}}, product_ff[49:12]};

   always_ff @(posedge clock) begin
      if (op != MUL_IDLE) begin
         product_ff <= product_in;
      end
      if (op == MUL_K2) begin
         k1_ff <= product_ff[31:16];
      end
      if (op == MUL_MOM) begin
         k2_ff <= product_ff[31:16];
      end
      if (op == MUL_OWN) begin
         acc_ff <= term;
      end else if (op == MUL_SWARM || op == MUL_SPAN) begin
         acc_ff <= acc_ff + term;
      end
   end

   assign product = product_ff;
   assign acc     = acc_ff;
endmodule

// File: hdl/pso_particle_update.sv
// Top level of the particle update block: request sequencer, per-dimension
// stores and result register. Depends on pso_pkg, pso_ram, pso_mac and the
// assertion macro header.

// One particle in Q16.16. A load or a cost that does not improve goes from
// dispatch straight to the done state. A move takes one store read, six
// passes through the single shared 17x33 multiplier (two gain-by-draw
// products, momentum, two attraction terms and the velocity limit), a velocity
// clamp and a position clamp. A cost that improves, and the first move before
// any best exists, first copy the position store into the best store one
// entry a cycle. The request side takes one item at a time; a finished result
// waits in an output register while the next request is transferred.
module pso_particle_update #(
   parameter int DIMENSIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pso_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pso_pkg::rsp_item_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import pso_pkg::*;

   localparam int AW = DIMENSIONS > 1 ? $clog2(DIMENSIONS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DIMENSIONS - 1);
   localparam logic [31:0]   DIM_LIMIT = 32'(DIMENSIONS);
   localparam logic signed [39:0] ACC_HI = 40'sd2147483647;
   localparam logic signed [39:0] ACC_LO = -40'sd2147483648;
   localparam logic signed [35:0] V_HI   = 36'sd2147483647;
   localparam logic signed [35:0] V_LO   = -36'sd2147483648;

   state_type state_ff, state_in;
   cfg_type   cfg_ff;
   req_item_type item_ff;
   rsp_item_type rsp_data_ff;
   logic rsp_valid_ff;
   logic best_valid_ff;
   logic signed [31:0] best_cost_ff;

   logic [AW-1:0] cnt_ff, sweep_addr_ff;
   logic sweep_wr_ff;

   logic signed [31:0] pos_ff, lo_ff, hi_ff, vel_ff, vnew_ff;
   logic signed [32:0] own_diff_ff, swarm_diff_ff, span_ff;
   logic signed [31:0] res_pos_ff, res_vel_ff;
   logic improved_ff;

   logic [AW+3:0] dim_wide;
   logic [AW-1:0] dim_addr, pos_rd_addr;
   logic dim_ok, cost_better, out_free;

   logic pos_we, vel_we, bnd_we;
   logic signed [31:0] pos_wdata, vel_wdata;
   mul_op_type mul_op;

   logic [31:0] pos_rd, vel_rd, best_rd, lo_rd, hi_rd;
   logic signed [49:0] product;
   logic signed [39:0] acc;

   logic signed [31:0] sum_sat, vnew;
   logic signed [33:0] vmax;
   logic signed [35:0] v36, vmax36, nvmax36, vc1, vc2;
   logic signed [32:0] np33, np_c1, np_c2;

   assign dim_wide    = {{AW{1'b0}}, item_ff.dim_index};
   assign dim_addr    = dim_wide[AW-1:0];
   assign dim_ok      = {28'd0, item_ff.dim_index} < DIM_LIMIT;
   assign cost_better = item_ff.cost_value < best_cost_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (item_ff.req_type)
               REQ_COST: state_in = cost_better ? ST_SWEEP : ST_DONE;
               REQ_MOVE: begin
                  if (!dim_ok) state_in = ST_DONE;
                  else if (best_valid_ff) state_in = ST_READ;
                  else state_in = ST_SWEEP;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            if (cnt_ff == LAST_ADDR) state_in = ST_SWEEP_TAIL;
         end
         ST_SWEEP_TAIL: state_in = (item_ff.req_type == REQ_MOVE) ? ST_READ : ST_DONE;
         ST_READ:  state_in = ST_K1;
         ST_K1:    state_in = ST_K2;
         ST_K2:    state_in = ST_MOM;
         ST_MOM:   state_in = ST_OWN;
         ST_OWN:   state_in = ST_SWARM;
         ST_SWARM: state_in = ST_SPAN;
         ST_SPAN:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_POS;
         ST_POS:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      mul_op      = MUL_IDLE;
      pos_we      = 1'b0;
      vel_we      = 1'b0;
      bnd_we      = 1'b0;
      pos_wdata   = item_ff.load_position;
      vel_wdata   = item_ff.load_velocity;
      pos_rd_addr = dim_addr;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DISPATCH: begin
            if (item_ff.req_type == REQ_LOAD && dim_ok) begin
               pos_we = 1'b1;
               vel_we = 1'b1;
               bnd_we = 1'b1;
            end
         end
         ST_SWEEP: pos_rd_addr = cnt_ff;
         ST_K1:    mul_op = MUL_K1;
         ST_K2:    mul_op = MUL_K2;
         ST_MOM:   mul_op = MUL_MOM;
         ST_OWN:   mul_op = MUL_OWN;
         ST_SWARM: mul_op = MUL_SWARM;
         ST_SPAN:  mul_op = MUL_SPAN;
         ST_POS: begin
            pos_we    = 1'b1;
            vel_we    = 1'b1;
            pos_wdata = np_c2[31:0];
            vel_wdata = vnew_ff;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // velocity: saturate the sum, clamp to +-vmax, saturate again
   always_comb begin
      if (acc > ACC_HI) sum_sat = 32'sh7FFF_FFFF;
      else if (acc < ACC_LO) sum_sat = 32'sh8000_0000;
      else sum_sat = acc[31:0];
      vmax    = product[49:16];
      v36     = {{4{sum_sat[31]}}, sum_sat};
      vmax36  = {{2{vmax[33]}}, vmax};
      nvmax36 = -vmax36;
      vc1     = (v36 > vmax36) ? vmax36 : v36;
      vc2     = (vc1 < nvmax36) ? nvmax36 : vc1;
      if (vc2 > V_HI) vnew = 32'sh7FFF_FFFF;
      else if (vc2 < V_LO) vnew = 32'sh8000_0000;
      else vnew = vc2[31:0];
   end

   // position: add and clamp to the bounds
   always_comb begin
      np33  = {pos_ff[31], pos_ff} + {vnew_ff[31], vnew_ff};
      np_c1 = (np33 > $signed({hi_ff[31], hi_ff})) ? $signed({hi_ff[31], hi_ff}) : np33;
      np_c2 = (np_c1 < $signed({lo_ff[31], lo_ff})) ? $signed({lo_ff[31], lo_ff}) : np_c1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         best_cost_ff  <= COST_MAX;
         sweep_wr_ff   <= 1'b0;
         cfg_ff.own_best_gain    <= OWN_GAIN_RST;
         cfg_ff.global_best_gain <= GLOBAL_GAIN_RST;
         cfg_ff.momentum_gain    <= MOMENTUM_RST;
         cfg_ff.vmax_fraction    <= VMAX_FRAC_RST;
      end else begin
         state_ff    <= state_in;
         sweep_wr_ff <= (state_ff == ST_SWEEP);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OWN_GAIN:    cfg_ff.own_best_gain    <= csr_wdata;
               CSR_GLOBAL_GAIN: cfg_ff.global_best_gain <= csr_wdata;
               CSR_MOMENTUM:    cfg_ff.momentum_gain    <= csr_wdata;
               CSR_VMAX_FRAC:   cfg_ff.vmax_fraction    <= csr_wdata;
               default:         cfg_ff.vmax_fraction    <= cfg_ff.vmax_fraction;
            endcase
         end
         if (state_ff == ST_DISPATCH && item_ff.req_type == REQ_COST && cost_better) begin
            best_cost_ff <= item_ff.cost_value;
         end
         if (state_ff == ST_SWEEP_TAIL) begin
            best_valid_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      sweep_addr_ff <= cnt_ff;
      if (state_ff == ST_DISPATCH) begin
         cnt_ff      <= '0;
         res_pos_ff  <= '0;
         res_vel_ff  <= '0;
         improved_ff <= (item_ff.req_type == REQ_COST) && cost_better;
      end else if (state_ff == ST_SWEEP) begin
         cnt_ff <= cnt_ff + AW'(1);
      end
      if (state_ff == ST_K1) begin
         pos_ff        <= pos_rd;
         vel_ff        <= vel_rd;
         lo_ff         <= lo_rd;
         hi_ff         <= hi_rd;
         own_diff_ff   <= {best_rd[31], best_rd} - {pos_rd[31], pos_rd};
         swarm_diff_ff <= {item_ff.swarm_best_coord[31], item_ff.swarm_best_coord}
                          - {pos_rd[31], pos_rd};
         span_ff       <= {hi_rd[31], hi_rd} - {lo_rd[31], lo_rd};
      end
      if (state_ff == ST_CLAMP) begin
         vnew_ff <= vnew;
      end
      if (state_ff == ST_POS) begin
         res_pos_ff <= np_c2[31:0];
         res_vel_ff <= vnew_ff;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff.new_position       <= res_pos_ff;
         rsp_data_ff.new_velocity       <= res_vel_ff;
         rsp_data_ff.improved           <= improved_ff;
         rsp_data_ff.personal_best_cost <= best_cost_ff;
      end
   end

   pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (dim_addr),
      .wr_data (pos_wdata),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd)
   );

   pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_vel_ram (
      .clock   (clock),
      .wr_en   (vel_we),
      .wr_addr (dim_addr),
      .wr_data (vel_wdata),
      .rd_addr (dim_addr),
      .rd_data (vel_rd)
   );

   pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_best_ram (
      .clock   (clock),
      .wr_en   (sweep_wr_ff),
      .wr_addr (sweep_addr_ff),
      .wr_data (pos_rd),
      .rd_addr (dim_addr),
      .rd_data (best_rd)
   );

   pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_lo_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (dim_addr),
      .wr_data (item_ff.bound_low),
      .rd_addr (dim_addr),
      .rd_data (lo_rd)
   );

   pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_hi_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (dim_addr),
      .wr_data (item_ff.bound_high),
      .rd_addr (dim_addr),
      .rd_data (hi_rd)
   );

   pso_mac u_mac (
      .clock       (clock),
      .op          (mul_op),
      .cfg         (cfg_ff),
      .rand_own    (item_ff.rand_own),
      .rand_global (item_ff.rand_global),
      .velocity    (vel_ff),
      .own_diff    (own_diff_ff),
      .swarm_diff  (swarm_diff_ff),
      .span        (span_ff),
      .product     (product),
      .acc         (acc)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "pso_particle_update_macros.svh"

   `PSO_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `PSO_ASSERT_NEXT(a_best_sticky, clock, reset, best_valid_ff, best_valid_ff)
   `PSO_ASSERT_NEXT(a_cost_falls, clock, reset, !reset, best_cost_ff <= $past(best_cost_ff))
   `PSO_ASSERT_SAME(a_copy_in_sweep, clock, reset, sweep_wr_ff,
                    state_ff == ST_SWEEP || state_ff == ST_SWEEP_TAIL)

endmodule

// File: bench/pso_particle_update_tb.sv
// Self-checking bench for pso_particle_update: loads, cost reports and moves
// checked against an in-bench fixed-point particle predictor.
// Depends on pso_pkg and pso_particle_update only.
module pso_particle_update_tb;
   import pso_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DIMS = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_wr_en;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   // predictor copy of the particle and its tuning
   logic signed [31:0] pos_mem [DIMS];
   logic signed [31:0] vel_mem [DIMS];
   logic signed [31:0] best_mem [DIMS];
   logic signed [31:0] low_mem [DIMS];
   logic signed [31:0] high_mem [DIMS];
   logic signed [31:0] best_cost = COST_MAX;
   logic               best_ok = 1'b0;
   logic [15:0]        own_gain = OWN_GAIN_RST;
   logic [15:0]        swarm_gain = GLOBAL_GAIN_RST;
   logic [15:0]        mom_gain = MOMENTUM_RST;
   logic [15:0]        vmax_frac = VMAX_FRAC_RST;

   rsp_item_type particle_results_due [$];
   rsp_item_type due;

   int unsigned send_gap_max = 16;
   int unsigned take_gap_max = 16;
   int          quiet_cycles = 0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          moves_sent = 0;
   int          improvements = 0;
   int          results_checked = 0;
   int          settings_used = 0;

   pso_particle_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint clip32(longint x);
      if (x > longint'(S32_MAX)) return longint'(S32_MAX);
      if (x < longint'(S32_MIN)) return longint'(S32_MIN);
      return x;
   endfunction

   function automatic rsp_item_type predict_particle(req_item_type it);
      rsp_item_type res;
      longint p, v, b, s, lo, hi, g1, g2, gm, gv, r1, r2, k1, k2, acc, vlim, np;
      int d;
      res = '0;
      d = it.dim_index;
      case (it.req_type)
         REQ_LOAD: begin
            pos_mem[d]  = it.load_position;
            vel_mem[d]  = it.load_velocity;
            low_mem[d]  = it.bound_low;
            high_mem[d] = it.bound_high;
         end
         REQ_COST: begin
            if (it.cost_value < best_cost) begin
               best_cost = it.cost_value;
               best_mem = pos_mem;
               best_ok = 1'b1;
               res.improved = 1'b1;
               improvements++;
            end
         end
         REQ_MOVE: begin
            if (!best_ok) begin
               best_mem = pos_mem;
               best_ok = 1'b1;
            end
            p = pos_mem[d];
            v = vel_mem[d];
            b = best_mem[d];
            lo = low_mem[d];
            hi = high_mem[d];
            s = it.swarm_best_coord;
            g1 = own_gain;
            g2 = swarm_gain;
            gm = mom_gain;
            gv = vmax_frac;
            r1 = it.rand_own;
            r2 = it.rand_global;
            k1 = (g1 * r1) >>> 16;
            k2 = (g2 * r2) >>> 16;
            acc = ((gm * v) >>> 12) + ((k1 * (b - p)) >>> 12) + ((k2 * (s - p)) >>> 12);
            acc = clip32(acc);
            vlim = (gv * (hi - lo)) >>> 16;
            if (acc > vlim) acc = vlim;
            if (acc < -vlim) acc = -vlim;
            acc = clip32(acc);
            np = p + acc;
            if (np > hi) np = hi;
            if (np < lo) np = lo;
            np = clip32(np);
            vel_mem[d] = acc[31:0];
            pos_mem[d] = np[31:0];
            res.new_position = np[31:0];
            res.new_velocity = acc[31:0];
            moves_sent++;
         end
         default: ;
      endcase
      res.personal_best_cost = best_cost;
      return res;
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      endcase
   endfunction

   function automatic req_item_type draw_item();
      req_item_type it;
      logic signed [31:0] a, b;
      it.req_type = REQ_MOVE;
      it.dim_index = 4'($urandom_range(0, DIMS - 1));
      it.load_position = pick_word();
      it.load_velocity = pick_word();
      it.bound_low = pick_word();
      it.bound_high = pick_word();
      it.cost_value = $urandom;
      it.rand_own = 16'($urandom);
      it.rand_global = 16'($urandom);
      it.swarm_best_coord = pick_word();
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            it.req_type = REQ_LOAD;
            a = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
            b = a + 32'($urandom_range(0, 32'h0100_0000));
            case ($urandom_range(0, 9))
               0: begin
                  it.bound_low = b;
                  it.bound_high = a;
               end
               1: begin
                  it.bound_low = S32_MIN;
                  it.bound_high = S32_MAX;
               end
               2: ;
               default: begin
                  it.bound_low = a;
                  it.bound_high = b;
               end
            endcase
         end
         4, 5, 6, 7: begin
            it.req_type = REQ_COST;
            case ($urandom_range(0, 19))
               0: it.cost_value = best_cost;
               1: it.cost_value = $urandom;
               2, 3, 4: it.cost_value = (best_cost < 32'sh7FFF_0000) ?
                  best_cost + 32'($urandom_range(1, 4095)) : best_cost;
               default: it.cost_value = (best_cost > 32'sh8001_0000) ?
                  best_cost - 32'($urandom_range(1, 50000)) : 32'($urandom);
            endcase
         end
         8: it.req_type = REQ_UNUSED;
         default: begin
            if ($urandom_range(0, 7) == 0)
               it.rand_own = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(0, 7) == 0)
               it.rand_global = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         end
      endcase
      return it;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic send_item(req_item_type it);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      particle_results_due.push_back(predict_particle(it));
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (particle_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_OWN_GAIN:    own_gain = value;
         CSR_GLOBAL_GAIN: swarm_gain = value;
         CSR_MOMENTUM:    mom_gain = value;
         CSR_VMAX_FRAC:   vmax_frac = value;
         default: ;
      endcase
   endtask

   task automatic set_gains(logic [15:0] c1, logic [15:0] c2, logic [15:0] m,
                            logic [15:0] vf);
      drain_results();
      csr_put(CSR_OWN_GAIN, c1);
      csr_put(CSR_GLOBAL_GAIN, c2);
      csr_put(CSR_MOMENTUM, m);
      csr_put(CSR_VMAX_FRAC, vf);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic load_dim(int d, logic signed [31:0] p, logic signed [31:0] v,
                           logic signed [31:0] lo, logic signed [31:0] hi);
      req_item_type it;
      it = '0;
      it.req_type = REQ_LOAD;
      it.dim_index = 4'(d);
      it.load_position = p;
      it.load_velocity = v;
      it.bound_low = lo;
      it.bound_high = hi;
      send_item(it);
   endtask

   task automatic move_dim(int d, logic [15:0] r1, logic [15:0] r2,
                           logic signed [31:0] swarm);
      req_item_type it;
      it = '0;
      it.req_type = REQ_MOVE;
      it.dim_index = 4'(d);
      it.rand_own = r1;
      it.rand_global = r2;
      it.swarm_best_coord = swarm;
      send_item(it);
   endtask

   task automatic report_cost(logic signed [31:0] c);
      req_item_type it;
      it = '0;
      it.req_type = REQ_COST;
      it.cost_value = c;
      send_item(it);
   endtask

   task automatic run_random_items(int count);
      int k;
      for (k = 0; k < count; k++) begin
         if (k % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: begin send_gap_max = 0;  take_gap_max = 0;  end
               1: begin send_gap_max = 16; take_gap_max = 0;  end
               2: begin send_gap_max = 0;  take_gap_max = 16; end
               default: begin send_gap_max = 16; take_gap_max = 16; end
            endcase
         end
         if (k == count / 2) drain_results();
         send_item(draw_item());
      end
   endtask

   // fill every dimension first so that no copy or move touches an unwritten entry
   task automatic test_directed_cases();
      req_item_type it;
      int d;
      load_dim(0, S32_MAX, S32_MIN, S32_MIN, S32_MAX);
      load_dim(1, '0, 32'sh0001_0000, 32'sh0010_0000, -32'sh0010_0000);
      load_dim(2, 32'sh0003_0000, -32'sh0005_0000, 32'sh0003_0000, 32'sh0003_0000);
      for (d = 3; d < DIMS; d++)
         load_dim(d, 32'(d) <<< 15, 32'(d) * 32'sh0000_1000 - 32'sh0000_8000,
                  -32'sh0040_0000, 32'sh0040_0000);
      report_cost(COST_MAX);
      move_dim(3, 16'hFFFF, 16'hFFFF, 32'sh0100_0000);
      report_cost(32'sh0000_1000);
      report_cost(32'sh0000_1000);
      it = '0;
      it.req_type = REQ_UNUSED;
      send_item(it);
      move_dim(0, 16'hFFFF, 16'h0000, S32_MIN);
      move_dim(0, 16'h0000, 16'hFFFF, S32_MAX);
      move_dim(1, 16'h8000, 16'h8000, 32'sh0020_0000);
      move_dim(2, 16'hFFFF, 16'hFFFF, -32'sh0020_0000);
      move_dim(15, 16'h1234, 16'hFEDC, 32'sh0000_0001);
   endtask

   task automatic test_gain_extremes();
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_items(150);
      set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_random_items(150);
      set_gains(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      run_random_items(100);
   endtask

   task automatic test_random_traffic();
      int n;
      for (n = 0; n < 5; n++) begin
         set_gains(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                   16'($urandom_range(0, 4096)), 16'($urandom));
         run_random_items(230);
      end
      set_gains(OWN_GAIN_RST, GLOBAL_GAIN_RST, MOMENTUM_RST, VMAX_FRAC_RST);
      run_random_items(230);
   endtask

   // the lowest cost pins the best for the rest of the run, so keep it last
   task automatic test_cost_floor();
      send_gap_max = 16;
      take_gap_max = 16;
      report_cost(S32_MIN);
      report_cost(S32_MIN);
      move_dim(4, 16'hFFFF, 16'hFFFF, 32'sh0000_8000);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = $urandom_range(0, take_gap_max);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (particle_results_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %h", rsp_data));
         end else begin
            due = particle_results_due.pop_front();
            compare_field("new_position", rsp_data.new_position, due.new_position);
            compare_field("new_velocity", rsp_data.new_velocity, due.new_velocity);
            compare_field("improved", 32'(rsp_data.improved), 32'(due.improved));
            compare_field("personal_best_cost", rsp_data.personal_best_cost,
                          due.personal_best_cost);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_OWN_GAIN;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_gain_extremes();
      test_random_traffic();
      test_cost_floor();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d requests (%0d moves, %0d improving costs) under %0d tunings;",
               items_sent, moves_sent, improvements, settings_used + 1);
      $display("%0d results checked, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/pso_pkg.sv
hdl/pso_ram.sv
hdl/pso_mac.sv
hdl/pso_particle_update.sv
bench/pso_particle_update_tb.sv
